FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on clk, switched off while rst is high.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication a |-> c.
`define ASSERT_IMPLY(lbl, clk, rst, a, c, msg) \
   `ASSERT_CLK(lbl, clk, rst, (a) |-> (c), msg)

`endif

FILE: design/crcfd_pkg.sv
// ----------------------------------------------------------------------------
// crcfd_pkg
// Types, constants and the CRC-8 byte update for the frame decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crcfd_pkg;

   localparam int unsigned BYTE_WIDTH      = 8;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   typedef logic [BYTE_WIDTH-1:0]      byte_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_START_BYTE  = 1'd0;
   localparam csr_index_type CSR_MAX_PAYLOAD = 1'd1;

   localparam byte_type START_BYTE_RESET  = 8'h7E;
   localparam byte_type MAX_PAYLOAD_RESET = 8'h20;

   // CRC-8/MAXIM, reflected form of polynomial 0x31
   localparam byte_type CRC_POLY_REFL = 8'h8C;
   localparam byte_type CRC_INIT      = 8'h00;

   typedef enum logic [5:0] {
      PH_WAIT    = 6'b000001,
      PH_ADDR    = 6'b000010,
      PH_CMD     = 6'b000100,
      PH_LEN     = 6'b001000,
      PH_PAYLOAD = 6'b010000,
      PH_CRC     = 6'b100000
   } phase_type;

   // one byte, LSB first, unrolled
   function automatic byte_type crc8_update(input byte_type crc, input byte_type data);
      byte_type c;
      byte_type d;
      logic     mix;
      c = crc;
      d = data;
      for (int k = 0; k < BYTE_WIDTH; k++) begin
         mix = c[0] ^ d[0];
         c   = c >> 1;
         if (mix) begin
            c = c ^ CRC_POLY_REFL;
         end
         d = d >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/crc8_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// crc8_frame_decoder_core
// Byte-serial parser for length-prefixed frames with a running CRC-8/MAXIM.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------
//   req_    | in  | req_valid / req_stall | rx_byte
//   rsp_    | out | rsp_valid / rsp_stall | payload, frame and error fields
//   csr_    | in  | csr_write_enable      | csr_index, csr_write_data
//
// One item per cycle sustained while rsp_stall stays low.
// An input register feeds the parser step; its result goes to an output register.
// The input register takes a new item while a result waits in the output register, if it is empty.
// reset is synchronous: parser hunts for the start byte, state and valid registers take defaults.
// req_stall rises only when both the input and output registers hold items and
// rsp_stall is high.
//
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crc8_frame_decoder_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // input item
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire crcfd_pkg::byte_type      req_rx_byte,
   // result item
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic                     rsp_payload_valid,
   output      crcfd_pkg::byte_type      rsp_payload_data,
   output      crcfd_pkg::byte_type      rsp_payload_index,
   output      logic                     rsp_frame_done,
   output      logic                     rsp_frame_good,
   output      crcfd_pkg::byte_type      rsp_frame_address,
   output      crcfd_pkg::byte_type      rsp_frame_command,
   output      crcfd_pkg::byte_type      rsp_frame_length,
   output      logic                     rsp_length_error,
   // configuration
   input  wire logic                     csr_write_enable,
   input  wire crcfd_pkg::csr_index_type csr_index,
   input  wire crcfd_pkg::byte_type      csr_write_data
);

   import crcfd_pkg::*;

   // configuration
   byte_type  start_byte_ff,  start_byte_in;
   byte_type  max_payload_ff, max_payload_in;

   // input stage
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff,  in_byte_in;

   // parser state
   phase_type phase_ff,   phase_in;
   byte_type  address_ff, address_in;
   byte_type  command_ff, command_in;
   byte_type  length_ff,  length_in;
   byte_type  count_ff,   count_in;
   byte_type  crc_ff,     crc_in;

   // output stage
   logic      out_valid_ff, out_valid_in;
   logic      pv_ff,   pv_in;
   byte_type  pd_ff,   pd_in;
   byte_type  pi_ff,   pi_in;
   logic      done_ff, done_in;
   logic      good_ff, good_in;
   logic      lerr_ff, lerr_in;

   logic      advance;
   byte_type  crc_next;
   byte_type  count_inc;

   // parser step fires when the input register has an item and the output slot frees
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign crc_next  = crc8_update(crc_ff, in_byte_ff);
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      start_byte_in  = start_byte_ff;
      max_payload_in = max_payload_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_START_BYTE:  start_byte_in  = csr_write_data;
            CSR_MAX_PAYLOAD: max_payload_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_byte_in  = in_byte_ff;
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      address_in = address_ff;
      command_in = command_ff;
      length_in  = length_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      pv_in   = pv_ff;
      pd_in   = pd_ff;
      pi_in   = pi_ff;
      done_in = done_ff;
      good_in = good_ff;
      lerr_in = lerr_ff;

      if (advance) begin
         out_valid_in = 1'b1;
         pv_in   = 1'b0;
         pd_in   = '0;
         pi_in   = '0;
         done_in = 1'b0;
         good_in = 1'b0;
         lerr_in = 1'b0;
         case (phase_ff)
            PH_WAIT: begin
               if (in_byte_ff == start_byte_ff) begin
                  phase_in = PH_ADDR;
                  crc_in   = CRC_INIT;
               end
            end
            PH_ADDR: begin
               address_in = in_byte_ff;
               crc_in     = crc_next;
               phase_in   = PH_CMD;
            end
            PH_CMD: begin
               command_in = in_byte_ff;
               crc_in     = crc_next;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               length_in = in_byte_ff;
               count_in  = '0;
               crc_in    = crc_next;
               if (in_byte_ff > max_payload_ff) begin
                  lerr_in  = 1'b1;
                  phase_in = PH_WAIT;
               end else if (in_byte_ff == '0) begin
                  phase_in = PH_CRC;
               end else begin
                  phase_in = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               pv_in    = 1'b1;
               pd_in    = in_byte_ff;
               pi_in    = count_ff;
               crc_in   = crc_next;
               count_in = count_inc;
               if (count_inc >= length_ff) begin
                  phase_in = PH_CRC;
               end
            end
            PH_CRC: begin
               done_in  = 1'b1;
               good_in  = (crc_ff == in_byte_ff);
               phase_in = PH_WAIT;
            end
            default: begin
               phase_in = PH_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= START_BYTE_RESET;
         max_payload_ff <= MAX_PAYLOAD_RESET;
         in_valid_ff    <= 1'b0;
         phase_ff       <= PH_WAIT;
         address_ff     <= '0;
         command_ff     <= '0;
         length_ff      <= '0;
         count_ff       <= '0;
         crc_ff         <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         start_byte_ff  <= start_byte_in;
         max_payload_ff <= max_payload_in;
         in_valid_ff    <= in_valid_in;
         phase_ff       <= phase_in;
         address_ff     <= address_in;
         command_ff     <= command_in;
         length_ff      <= length_in;
         count_ff       <= count_in;
         crc_ff         <= crc_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      pv_ff      <= pv_in;
      pd_ff      <= pd_in;
      pi_ff      <= pi_in;
      done_ff    <= done_in;
      good_ff    <= good_in;
      lerr_ff    <= lerr_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = pv_ff;
   assign rsp_payload_data  = pd_ff;
   assign rsp_payload_index = pi_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_frame_good    = good_ff;
   assign rsp_frame_address = address_ff;
   assign rsp_frame_command = command_ff;
   assign rsp_frame_length  = length_ff;
   assign rsp_length_error  = lerr_ff;

   // a waiting result always matches the parser state it left behind; payload count and item flags stay consistent
   `ASSERT_IMPLY(a_end_in_hunt, clock, reset,
      out_valid_ff && (done_ff || lerr_ff), phase_ff == PH_WAIT,
      "frame end or length error without return to hunting")
   `ASSERT_IMPLY(a_payload_bound, clock, reset,
      phase_ff == PH_PAYLOAD, count_ff < length_ff,
      "payload count reached held length inside payload phase")
   `ASSERT_IMPLY(a_kind_exclusive, clock, reset,
      out_valid_ff, !(pv_ff && (done_ff || lerr_ff)) && !(done_ff && lerr_ff),
      "more than one item kind flagged")
   `ASSERT_IMPLY(a_good_needs_done, clock, reset,
      out_valid_ff && good_ff, done_ff,
      "frame_good without frame_done")

endmodule

`default_nettype wire
